// ===== rtl/sha1_pkg.sv =====
// shared types and constants for the byte-stream sha-1 hasher
// no dependencies
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int unsigned BlockBytes = 64;

  typedef enum logic [3:0] {
    ST_IDLE,     // ready for a byte
    ST_LOAD,     // load 16 schedule words from the buffer
    ST_ROUND,    // 80 rounds, one per cycle
    ST_ADD,      // fold round words into chain
    ST_PAD,      // write padding bytes one per cycle
    ST_LEN,      // write length bytes
    ST_DIGEST2,  // feed digest bytes back for the second pass
    ST_OUT       // emit five digest words
  } state_e;

  // why a compression was started, decides what follows it
  typedef enum logic [1:0] {
    CR_FULL,     // buffer filled by a data byte
    CR_PADFULL,  // padding overflowed into an extra block
    CR_LAST      // final block of a message
  } cause_e;

  // control from the sequencer to the round core
  typedef struct packed {
    logic       init;   // load round words from chain
    logic       step;   // run one round
    logic       fold;   // add round words into chain
    logic       reset;  // chain back to initial values
    logic [6:0] round;
  } core_ctrl_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20) return 32'h5A827999;
    else if (t < 7'd40) return 32'h6ED9EBA1;
    else if (t < 7'd60) return 32'h8F1BBCDC;
    else return 32'hCA62C1D6;
  endfunction

endpackage

// ===== rtl/sha1_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module sha1_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/sha1_core.sv =====
// sha-1 round core: chain words, round words and 16-word rolling schedule
// depends on sha1_pkg
module sha1_core import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  core_ctrl_t  ctrl_i,
  input  logic        sched_we_i,   // shift a loaded word into the schedule
  input  logic [31:0] sched_wd_i,
  output logic [31:0] chain_o [5]
);
  logic [31:0] chain_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] w_q [16];
  logic [31:0] f, w, wx, tmp;

  // schedule is kept as a shift line: w_q[0] is the word of this round for rounds below 16
  always_comb begin
    wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w  = (ctrl_i.round < 7'd16) ? w_q[0] : {wx[30:0], wx[31]};
    if (ctrl_i.round < 7'd20) f = (b_q & c_q) | (~b_q & d_q);
    else if (ctrl_i.round < 7'd40) f = b_q ^ c_q ^ d_q;
    else if (ctrl_i.round < 7'd60) f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
    else f = b_q ^ c_q ^ d_q;
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + round_k(ctrl_i.round) + w;
  end

  // for rounds >= 16 the shift line holds w[t-16..t-1]; new word goes to the tail
  logic [31:0] wnext;
  assign wnext = {wx[30:0], wx[31]};

  // rounds below 16 rotate the loaded words; later rounds append the new one
  logic [31:0] wnext_sel;
  assign wnext_sel = (ctrl_i.round < 7'd16) ? w_q[0] : wnext;

  always_ff @(posedge clk_i) begin
    if (sched_we_i || ctrl_i.step) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
    end
    if (sched_we_i) begin
      w_q[15] <= sched_wd_i;
    end else if (ctrl_i.step) begin
      w_q[15] <= wnext_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= H0; chain_q[1] <= H1; chain_q[2] <= H2;
      chain_q[3] <= H3; chain_q[4] <= H4;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
    end else begin
      if (ctrl_i.reset) begin
        chain_q[0] <= H0; chain_q[1] <= H1; chain_q[2] <= H2;
        chain_q[3] <= H3; chain_q[4] <= H4;
      end else if (ctrl_i.fold) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
      if (ctrl_i.init) begin
        a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2];
        d_q <= chain_q[3]; e_q <= chain_q[4];
      end else if (ctrl_i.step) begin
        e_q <= d_q;
        d_q <= c_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        b_q <= a_q;
        a_q <= tmp;
      end
    end
  end

  assign chain_o = chain_q;

`ifndef ASSERT_OFF
  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.step && ctrl_i.init)) else $error("init during round");
  a_no_fold_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.fold && (ctrl_i.step || sched_we_i))) else $error("fold overlaps work");
  a_round_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |-> ctrl_i.round < 7'd80) else $error("round out of range");
`endif
endmodule

// ===== rtl/sha1_byte_stream_hasher.sv =====
// sha-1 byte stream hasher top level: sequencer, block buffer and length count
// depends on sha1_pkg, sha1_ram, sha1_core
//
// Takes at most one message byte per accepted word and returns the 160-bit
// SHA-1 digest as five 32-bit words after a word with end_of_message set;
// with hash_twice set the digest is hashed again first. A byte that does not
// complete the 64-byte block is written to the buffer and the next word may
// follow at once. A byte that completes the block starts a compression
// (buffer reads into the schedule, the 80 rounds one per cycle on the
// single round adder, then a fold into the chain), with in_stall_o high
// meanwhile. A closing word then writes padding and length one byte a
// cycle up to the end of the block, or of an extra block when the pad byte
// lands past byte 55, each block followed by a compression. With hash_twice
// set, the digest bytes are fed back, padding and length fill the block,
// and one more compression follows.
// The five digest words then leave one per taken word; input stays stalled
// until the last one is taken.
module sha1_byte_stream_hasher import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        final_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  state_e     state_q, state_d;
  cause_e     cause_q, cause_d;
  logic [5:0] fill_q, fill_d;         // bytes in block
  logic [63:0] bits_q, bits_d;
  logic [6:0] cnt_q, cnt_d;           // load/round/pad/digest counter
  logic       twice_q, second_q, second_d, end_q, end_d;
  logic [2:0] onum_q, onum_d;
  logic [23:0] ld_q, ld_d;            // assembles schedule words
  logic       we;
  logic [5:0] addr;
  logic [7:0] wd, rd;
  core_ctrl_t ctrl;
  logic       sched_we;
  logic [31:0] chain [5];
  logic       in_acc;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) twice_q <= 1'b0;
    else if (cfg_valid_i && cfg_ready_o) twice_q <= cfg_data_i;
  end

  sha1_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wd), .rdata_o(rd)
  );

  sha1_core u_core (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .sched_we_i(sched_we),
    .sched_wd_i({ld_q, rd}), .chain_o(chain)
  );

  // digest byte i of the first pass, read from the chain before it restarts
  logic [31:0] dsel;
  logic [7:0]  dbyte;
  always_comb begin
    dsel = chain[cnt_q[4:2]];
    unique case (cnt_q[1:0])
      2'd0:    dbyte = dsel[31:24];
      2'd1:    dbyte = dsel[23:16];
      2'd2:    dbyte = dsel[15:8];
      default: dbyte = dsel[7:0];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_present_i && fill_q == 6'd63) state_d = ST_LOAD;
          else if (end_of_message_i) state_d = ST_PAD;
        end
      end
      ST_LOAD:   if (cnt_q == 7'd64) state_d = ST_ROUND;
      ST_ROUND:  if (cnt_q == 7'd79) state_d = ST_ADD;
      ST_ADD: begin
        unique case (cause_q)
          CR_FULL:    state_d = second_q ? ST_DIGEST2 : (end_q ? ST_PAD : ST_IDLE);
          CR_PADFULL: state_d = ST_PAD;
          default:    state_d = (twice_q && !second_q) ? ST_DIGEST2 : ST_OUT;
        endcase
      end
      ST_PAD: begin
        if (fill_q == 6'd63) state_d = ST_LOAD;
        else if (fill_q == 6'd55) state_d = ST_LEN;
      end
      ST_LEN:    if (fill_q == 6'd63) state_d = ST_LOAD;
      ST_DIGEST2: if (cnt_q == 7'd19) state_d = ST_PAD;
      ST_OUT:    if (!out_stall_i && onum_q == 3'd4) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cause_d = cause_q; fill_d = fill_q; bits_d = bits_q; cnt_d = cnt_q;
    second_d = second_q; end_d = end_q; onum_d = onum_q; ld_d = ld_q;
    we = 1'b0; addr = fill_q; wd = message_byte_i;
    ctrl = '0; ctrl.round = cnt_q; sched_we = 1'b0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          end_d = end_of_message_i;
          second_d = 1'b0;
          if (byte_present_i) begin
            we = 1'b1;
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
            cause_d = CR_FULL;
          end
        end
      end
      ST_LOAD: begin
        // address leads data; the byte comes back in the cycle after its address
        addr = cnt_q[5:0];
        if (cnt_q != 7'd0) begin
          ld_d = {ld_q[15:0], rd};
          sched_we = (cnt_q[1:0] == 2'd0);
        end
        cnt_d = (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
        ctrl.init = (cnt_q == 7'd64);
      end
      ST_ROUND: begin
        ctrl.step = 1'b1;
        cnt_d = (cnt_q == 7'd79) ? 7'd0 : cnt_q + 7'd1;
      end
      ST_ADD: begin
        ctrl.fold = 1'b1;
        fill_d = '0;
        // after the last block the count restarts for the next message
        if (cause_q == CR_LAST) bits_d = '0;
        else cause_d = CR_FULL;
        // a block after a pad overflow starts with zeros, no pad byte
        cnt_d = (cause_q == CR_PADFULL) ? 7'd1 : 7'd0;
      end
      ST_PAD: begin
        we = 1'b1;
        wd = (cnt_q == 7'd0) ? PadByte : 8'h00;
        cnt_d = 7'd1;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          cause_d = CR_PADFULL;
          cnt_d = 7'd0;
        end else if (fill_q == 6'd55) begin
          cnt_d = 7'd0;
        end
      end
      ST_LEN: begin
        we = 1'b1;
        wd = bits_q[{~fill_q[2:0], 3'b111} -: 8];
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) cause_d = CR_LAST;
      end
      ST_DIGEST2: begin
        we = 1'b1;
        wd = dbyte;
        fill_d = fill_q + 6'd1;
        bits_d = bits_q + 64'd8;
        cnt_d = (cnt_q == 7'd19) ? 7'd0 : cnt_q + 7'd1;
        second_d = 1'b1;
        end_d = 1'b1;
      end
      ST_OUT: begin
        if (!out_stall_i) onum_d = onum_q + 3'd1;
        if (!out_stall_i && onum_q == 3'd4) onum_d = '0;
      end
      default: ;
    endcase
    // chain restarts once the last digest byte or word has been used
    ctrl.reset = (state_q == ST_OUT && !out_stall_i && onum_q == 3'd4) ||
                 (state_q == ST_DIGEST2 && cnt_q == 7'd19);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cause_q <= CR_FULL; fill_q <= '0; bits_q <= '0;
      cnt_q <= '0; second_q <= 1'b0; end_q <= 1'b0; onum_q <= '0;
    end else begin
      state_q <= state_d; cause_q <= cause_d; fill_q <= fill_d; bits_q <= bits_d;
      second_q <= second_d; end_q <= end_d; onum_q <= onum_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q <= ld_d;
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain[onum_q];
  assign word_number_o = onum_q;
  assign final_word_o  = (onum_q == 3'd4);

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accepting while busy");
  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !final_word_o) |=> out_valid_o)
    else $error("digest words broken off");
  a_num_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> word_number_o <= 3'd4) else $error("word number range");
`endif
endmodule

// ===== test/sha1_digest_checker.sv =====
// digest checker for the byte-stream sha-1 hasher: watches the byte, digest
// and config channels, keeps its own sha-1 state and compares each word
// depends on nothing but the hasher's port signals
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_number_i,
  input  logic        final_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int          mismatch_count_o,
  output int          words_pending_o,
  output int          words_taken_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  number;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];

  logic [31:0] chain[5];
  logic [31:0] digest[5];
  logic [7:0]  blk_bytes[64];
  int unsigned fill;
  logic [63:0] bit_count;
  logic        twice;

  function automatic logic [31:0] rol(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic restart_message();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    chain[4] = 32'hC3D2E1F0;
    fill = 0;
    bit_count = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16)
        w[t%16] = rol(w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16], 1);
      if (t < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      tmp = rol(a, 5) + f + e + k + w[t%16];
      e = d; d = c; c = rol(b, 30); b = a; a = tmp;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic take_byte(input logic [7:0] value);
    blk_bytes[fill] = value;
    fill++;
    bit_count += 64'd8;
    if (fill == 64) begin
      compress_block();
      fill = 0;
    end
  endtask

  task automatic close_message();
    int unsigned n;
    n = fill;
    blk_bytes[n] = 8'h80;
    n++;
    if (n > 56) begin
      while (n < 64) begin
        blk_bytes[n] = 8'h00;
        n++;
      end
      compress_block();
      n = 0;
    end
    while (n < 56) begin
      blk_bytes[n] = 8'h00;
      n++;
    end
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_count[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 5; i++) digest[i] = chain[i];
    restart_message();
  endtask

  task automatic predict_word(input logic [7:0] value, input logic present,
                              input logic eom);
    digest_word_t exp_word;
    if (present) take_byte(value);
    if (eom) begin
      close_message();
      if (twice) begin
        for (int i = 0; i < 20; i++) take_byte(digest[i/4][31-8*(i%4) -: 8]);
        close_message();
      end
      for (int i = 0; i < 5; i++) begin
        exp_word.word = digest[i];
        exp_word.number = 3'(i);
        exp_word.last = (i == 4);
        digest_q.push_back(exp_word);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_word;
    if (!rst_ni) begin
      restart_message();
      twice = 1'b0;
      digest_q.delete();
      mismatch_count_o = 0;
      words_taken_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) twice = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        predict_word(message_byte_i, byte_present_i, end_of_message_i);
      if (out_valid_i && !out_stall_i) begin
        words_taken_o++;
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected word", digest_word_i, '0);
        end else begin
          exp_word = digest_q.pop_front();
          if (digest_word_i !== exp_word.word)
            report_mismatch("digest_word", digest_word_i, exp_word.word);
          if (word_number_i !== exp_word.number)
            report_mismatch("word_number", 32'(word_number_i), 32'(exp_word.number));
          if (final_word_i !== exp_word.last)
            report_mismatch("final_word", 32'(final_word_i), 32'(exp_word.last));
        end
      end
    end
    words_pending_o = digest_q.size();
  end

endmodule

// ===== test/tb_sha1_byte_stream_hasher.sv =====
// testbench top for the byte-stream sha-1 hasher: random messages, idle gaps,
// config phases and verdict; depends on sha1_byte_stream_hasher and
// sha1_digest_checker
module tb_sha1_byte_stream_hasher;

  localparam int SettleCycles = 600;
  localparam int WatchdogLimit = 8000;
  localparam int ItemTarget = 330;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  message_byte_i;
  logic        byte_present_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_number_o;
  logic        final_word_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;
  int          mismatch_count;
  int          words_pending;
  int          words_taken;
  int          items_sent;
  int          idle_cycles;
  logic        no_gaps;

  sha1_byte_stream_hasher i_dut (.*);

  sha1_digest_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .message_byte_i,
    .byte_present_i, .end_of_message_i, .out_valid_i(out_valid_o), .out_stall_i,
    .digest_word_i(digest_word_o), .word_number_i(word_number_o),
    .final_word_i(final_word_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .mismatch_count_o(mismatch_count), .words_pending_o(words_pending),
    .words_taken_o(words_taken)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_item(input logic [7:0] value, input logic present,
                           input logic eom);
    int gap;
    gap = no_gaps ? 0 : gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    message_byte_i <= value;
    byte_present_i <= present;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // message of random bytes; the last byte rides on the closing word
  task automatic send_message(input int length);
    no_gaps = ($urandom_range(0, 3) == 0);
    if (length == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < length; i++)
        send_item(8'($urandom), 1'b1, i == length - 1);
    end
  endtask

  task automatic write_twice(input logic value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // one edge first so the checker has queued the last closing word
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int message_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 90) begin
      case ($urandom_range(0, 7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    return $urandom_range(13, 70);
  endfunction

  // receiver: random stalls, one long hold-off once random traffic is running
  initial begin
    int hold;
    int run;
    bit held;
    held = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && words_taken >= 40) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (700) @(posedge clk_i);
      end
      hold = gap_length();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no handshake on any channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("sha1_byte_stream_hasher test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    message_byte_i = '0;
    byte_present_i = 1'b0;
    end_of_message_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    items_sent = 0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_twice(1'b0);
    // directed: empty message, ignored word, byte extremes, byte with end
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h3C, 1'b0, 1'b1);
    drain();

    write_twice(1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    drain();

    write_twice(1'b0);
    while (items_sent < ItemTarget / 2) send_message(message_length());
    drain();

    write_twice(1'b1);
    while (items_sent < ItemTarget) send_message(message_length());
    drain();

    write_twice(1'b0);
    send_message(3);
    drain();

    if (mismatch_count == 0 && words_pending == 0)
      $display("sha1_byte_stream_hasher test passed");
    else
      $display("sha1_byte_stream_hasher test failed");
    $finish;
  end

endmodule

// ===== sha1_byte_stream_hasher.f =====
rtl/sha1_pkg.sv
rtl/sha1_ram.sv
rtl/sha1_core.sv
rtl/sha1_byte_stream_hasher.sv
test/sha1_digest_checker.sv
test/tb_sha1_byte_stream_hasher.sv
